>>> sv/sorted_key_value_table_defines.svh
// assertion macros for the sorted key/value table
// no dependencies; included by the top level only
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SKVT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skvt check failed");
// next-cycle implication
`define SKVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skvt check failed");
`else
`define SKVT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SKVT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/skvt_pkg.sv
// shared constants, codes and control types of the sorted key/value table
// no dependencies; used by controller, datapath and top level
package skvt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // request codes; the two highest codes are unused and do nothing
  localparam logic [2:0] REQ_LOOKUP     = 3'd0;
  localparam logic [2:0] REQ_READ_POS   = 3'd1;
  localparam logic [2:0] REQ_ADD        = 3'd2;
  localparam logic [2:0] REQ_SET        = 3'd3;
  localparam logic [2:0] REQ_REMOVE_KEY = 3'd4;
  localparam logic [2:0] REQ_REMOVE_POS = 3'd5;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_BAD_POS
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_POS,
    S_POS_TAKE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROBE,
    OP_NARROW,
    OP_TAKE_HIT,
    OP_FAIL,
    OP_POS_READ,
    OP_TAKE_POS,
    OP_SET_WRITE,
    OP_INS_HIT,
    OP_INS_MISS,
    OP_SHIFT_UP,
    OP_INS_WRITE,
    OP_SHIFT_DN,
    OP_DEL_END,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t fail_code;
  } dp_cmd_t;

  typedef struct packed {
    logic search_open;
    logic key_eq;
    logic full;
    logic pos_ok;
    logic up_busy;
    logic dn_busy;
  } dp_stat_t;

endpackage

>>> sv/skvt_datapath.sv
// datapath of the sorted key/value table: entry memory, search bounds,
// shift pointer, result and output registers; driven by skvt_controller
// depends on skvt_pkg
module skvt_datapath #(
  parameter int TABLE_DEPTH = skvt_pkg::TABLE_DEPTH,
  parameter int KEY_WIDTH   = skvt_pkg::KEY_WIDTH,
  parameter int VALUE_WIDTH = skvt_pkg::VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  skvt_pkg::dp_cmd_t                cmd,
  output skvt_pkg::dp_stat_t               stat,
  input  logic [KEY_WIDTH-1:0]             req_key,
  input  logic [VALUE_WIDTH-1:0]           req_value,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   req_position,
  output skvt_pkg::status_t                status,
  output logic                             key_existed,
  output logic [KEY_WIDTH-1:0]             found_key,
  output logic [VALUE_WIDTH-1:0]           found_value,
  output logic [$clog2(TABLE_DEPTH)-1:0]   entry_position,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_WIDTH + VALUE_WIDTH;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data;

  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [EW-1:0]          mem_wdata;

  logic [KEY_WIDTH-1:0]   req_key_r;
  logic [VALUE_WIDTH-1:0] req_value_r;
  logic [AW-1:0]          req_pos_r;
  logic [CW-1:0]          count;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [AW-1:0]          mid_r;
  logic [CW-1:0]          at;
  logic [CW-1:0]          ptr;
  logic [AW-1:0]          wr_addr;
  logic                   wr_pend;

  skvt_pkg::status_t      res_status;
  logic                   res_existed;
  logic [KEY_WIDTH-1:0]   res_key;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [AW-1:0]          res_pos;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [CW-1:0]          span;
  logic [CW-1:0]          mid_w;
  logic [CW-1:0]          ptr_dec;
  logic                   up_more;
  logic                   dn_more;

  assign rd_key   = rd_data[EW-1:VALUE_WIDTH];
  assign rd_value = rd_data[VALUE_WIDTH-1:0];
  assign span     = hi - lo;
  assign mid_w    = lo + (span >> 1);
  assign ptr_dec  = ptr - CW'(1);
  assign up_more  = ptr > at;
  assign dn_more  = ptr < count;

  assign stat.search_open = lo < hi;
  assign stat.key_eq      = rd_key == req_key_r;
  assign stat.full        = count == CW'(TABLE_DEPTH);
  assign stat.pos_ok      = CW'(req_pos_r) < count;
  assign stat.up_busy     = up_more || wr_pend;
  assign stat.dn_busy     = dn_more || wr_pend;

  // memory port selection
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = {req_key_r, req_value_r};
    unique case (cmd.op)
      skvt_pkg::OP_PROBE: begin
        mem_re    = 1'b1;
        mem_raddr = mid_w[AW-1:0];
      end
      skvt_pkg::OP_POS_READ: begin
        mem_re    = 1'b1;
        mem_raddr = req_pos_r;
      end
      skvt_pkg::OP_SET_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = mid_r;
      end
      skvt_pkg::OP_INS_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = at[AW-1:0];
      end
      skvt_pkg::OP_SHIFT_UP: begin
        // read the entry below, write the one fetched last cycle
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
        mem_wdata = rd_data;
        mem_re    = up_more;
        mem_raddr = ptr_dec[AW-1:0];
      end
      skvt_pkg::OP_SHIFT_DN: begin
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
        mem_wdata = rd_data;
        mem_re    = dn_more;
        mem_raddr = ptr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      unique case (cmd.op)
        skvt_pkg::OP_LOAD:      wr_pend <= 1'b0;
        skvt_pkg::OP_SHIFT_UP:  wr_pend <= up_more;
        skvt_pkg::OP_SHIFT_DN:  wr_pend <= dn_more;
        skvt_pkg::OP_INS_WRITE: count   <= count + CW'(1);
        skvt_pkg::OP_DEL_END:   count   <= count - CW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      skvt_pkg::OP_LOAD: begin
        req_key_r   <= req_key;
        req_value_r <= req_value;
        req_pos_r   <= req_position;
        lo          <= '0;
        hi          <= count;
        res_status  <= skvt_pkg::ST_OK;
        res_existed <= 1'b0;
        res_key     <= '0;
        res_value   <= '0;
        res_pos     <= '0;
      end
      skvt_pkg::OP_PROBE: mid_r <= mid_w[AW-1:0];
      skvt_pkg::OP_NARROW: begin
        if (rd_key > req_key_r) begin
          hi <= CW'(mid_r);
        end else begin
          lo <= CW'(mid_r) + CW'(1);
        end
      end
      skvt_pkg::OP_TAKE_HIT: begin
        res_key   <= rd_key;
        res_value <= rd_value;
        res_pos   <= mid_r;
        at        <= CW'(mid_r);
        ptr       <= CW'(mid_r) + CW'(1);
      end
      skvt_pkg::OP_FAIL: res_status <= cmd.fail_code;
      skvt_pkg::OP_TAKE_POS: begin
        res_key   <= rd_key;
        res_value <= rd_value;
        res_pos   <= req_pos_r;
        at        <= CW'(req_pos_r);
        ptr       <= CW'(req_pos_r) + CW'(1);
      end
      skvt_pkg::OP_SET_WRITE: begin
        res_existed <= 1'b1;
        res_key     <= req_key_r;
        res_value   <= req_value_r;
        res_pos     <= mid_r;
      end
      skvt_pkg::OP_INS_HIT: begin
        // duplicate key goes in at the equal entry found
        at        <= CW'(mid_r);
        res_pos   <= mid_r;
        res_key   <= req_key_r;
        res_value <= req_value_r;
        ptr       <= count;
      end
      skvt_pkg::OP_INS_MISS: begin
        at        <= hi;
        res_pos   <= hi[AW-1:0];
        res_key   <= req_key_r;
        res_value <= req_value_r;
        ptr       <= count;
      end
      skvt_pkg::OP_SHIFT_UP: begin
        if (up_more) begin
          wr_addr <= ptr[AW-1:0];
          ptr     <= ptr_dec;
        end
      end
      skvt_pkg::OP_SHIFT_DN: begin
        if (dn_more) begin
          wr_addr <= ptr_dec[AW-1:0];
          ptr     <= ptr + CW'(1);
        end
      end
      skvt_pkg::OP_EMIT: begin
        status         <= res_status;
        key_existed    <= res_existed;
        found_key      <= res_key;
        found_value    <= res_value;
        entry_position <= res_pos;
        entry_count    <= count;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/skvt_controller.sv
// control state machine of the sorted key/value table: sequences search,
// position read, shifts and the result transfer; depends on skvt_pkg
module skvt_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output skvt_pkg::dp_cmd_t  cmd,
  input  skvt_pkg::dp_stat_t stat
);

  skvt_pkg::state_t state;
  skvt_pkg::state_t state_next;
  logic [2:0]       op_type;
  logic             accept;
  logic             emit;
  logic             key_request;

  assign req_stall   = state != skvt_pkg::S_IDLE;
  assign accept      = req_valid && !req_stall;
  assign emit        = (state == skvt_pkg::S_FINISH) && (!rsp_valid || !rsp_stall);
  assign key_request = (op_type == skvt_pkg::REQ_LOOKUP) ||
                       (op_type == skvt_pkg::REQ_REMOVE_KEY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skvt_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_type <= req_type;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      skvt_pkg::S_IDLE: begin
        if (accept) begin
          priority if (req_type == skvt_pkg::REQ_LOOKUP || req_type == skvt_pkg::REQ_ADD ||
                       req_type == skvt_pkg::REQ_SET ||
                       req_type == skvt_pkg::REQ_REMOVE_KEY) begin
            state_next = skvt_pkg::S_SEARCH;
          end else if (req_type == skvt_pkg::REQ_READ_POS ||
                       req_type == skvt_pkg::REQ_REMOVE_POS) begin
            state_next = skvt_pkg::S_POS;
          end else begin
            state_next = skvt_pkg::S_FINISH;
          end
        end
      end
      skvt_pkg::S_SEARCH: begin
        priority if (stat.search_open) begin
          state_next = skvt_pkg::S_COMPARE;
        end else if (key_request || stat.full) begin
          state_next = skvt_pkg::S_FINISH;
        end else begin
          state_next = skvt_pkg::S_SHIFT_UP;
        end
      end
      skvt_pkg::S_COMPARE: begin
        if (!stat.key_eq) begin
          state_next = skvt_pkg::S_SEARCH;
        end else begin
          unique case (op_type)
            skvt_pkg::REQ_REMOVE_KEY: state_next = skvt_pkg::S_SHIFT_DN;
            skvt_pkg::REQ_ADD: begin
              state_next = stat.full ? skvt_pkg::S_FINISH : skvt_pkg::S_SHIFT_UP;
            end
            default: state_next = skvt_pkg::S_FINISH;
          endcase
        end
      end
      skvt_pkg::S_POS: begin
        state_next = stat.pos_ok ? skvt_pkg::S_POS_TAKE : skvt_pkg::S_FINISH;
      end
      skvt_pkg::S_POS_TAKE: begin
        state_next = (op_type == skvt_pkg::REQ_REMOVE_POS) ? skvt_pkg::S_SHIFT_DN
                                                            : skvt_pkg::S_FINISH;
      end
      skvt_pkg::S_SHIFT_UP: begin
        if (!stat.up_busy) begin
          state_next = skvt_pkg::S_FINISH;
        end
      end
      skvt_pkg::S_SHIFT_DN: begin
        if (!stat.dn_busy) begin
          state_next = skvt_pkg::S_FINISH;
        end
      end
      skvt_pkg::S_FINISH: begin
        if (emit) begin
          state_next = skvt_pkg::S_IDLE;
        end
      end
      default: state_next = skvt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = skvt_pkg::OP_NONE;
    cmd.fail_code = skvt_pkg::ST_OK;
    unique case (state)
      skvt_pkg::S_IDLE: begin
        if (accept) begin
          cmd.op = skvt_pkg::OP_LOAD;
        end
      end
      skvt_pkg::S_SEARCH: begin
        priority if (stat.search_open) begin
          cmd.op = skvt_pkg::OP_PROBE;
        end else if (key_request) begin
          cmd.op        = skvt_pkg::OP_FAIL;
          cmd.fail_code = skvt_pkg::ST_NOT_FOUND;
        end else if (stat.full) begin
          cmd.op        = skvt_pkg::OP_FAIL;
          cmd.fail_code = skvt_pkg::ST_FULL;
        end else begin
          cmd.op = skvt_pkg::OP_INS_MISS;
        end
      end
      skvt_pkg::S_COMPARE: begin
        if (!stat.key_eq) begin
          cmd.op = skvt_pkg::OP_NARROW;
        end else begin
          unique case (op_type)
            skvt_pkg::REQ_SET: cmd.op = skvt_pkg::OP_SET_WRITE;
            skvt_pkg::REQ_ADD: begin
              if (stat.full) begin
                cmd.op        = skvt_pkg::OP_FAIL;
                cmd.fail_code = skvt_pkg::ST_FULL;
              end else begin
                cmd.op = skvt_pkg::OP_INS_HIT;
              end
            end
            default: cmd.op = skvt_pkg::OP_TAKE_HIT;
          endcase
        end
      end
      skvt_pkg::S_POS: begin
        if (stat.pos_ok) begin
          cmd.op = skvt_pkg::OP_POS_READ;
        end else begin
          cmd.op        = skvt_pkg::OP_FAIL;
          cmd.fail_code = skvt_pkg::ST_BAD_POS;
        end
      end
      skvt_pkg::S_POS_TAKE: cmd.op = skvt_pkg::OP_TAKE_POS;
      skvt_pkg::S_SHIFT_UP: begin
        cmd.op = stat.up_busy ? skvt_pkg::OP_SHIFT_UP : skvt_pkg::OP_INS_WRITE;
      end
      skvt_pkg::S_SHIFT_DN: begin
        cmd.op = stat.dn_busy ? skvt_pkg::OP_SHIFT_DN : skvt_pkg::OP_DEL_END;
      end
      skvt_pkg::S_FINISH: begin
        if (emit) begin
          cmd.op = skvt_pkg::OP_EMIT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/sorted_key_value_table.sv
// Sorted key/value table: up to TABLE_DEPTH entries kept in ascending key order in a
// single-port-write, registered-read memory, one request at a time. A request is taken
// when the table is idle, even while the previous result still waits on the response side.
// Each search step reads the memory, then compares the key. An add or remove that moves
// entries shifts count - position entries for add, one fewer for remove. No clearing
// pass is needed after reset: only entries below the used count are ever read.
// depends on skvt_pkg, skvt_controller, skvt_datapath and the assertion macro header
`include "sorted_key_value_table_defines.svh"

module sorted_key_value_table #(
  parameter int TABLE_DEPTH = skvt_pkg::TABLE_DEPTH,
  parameter int KEY_WIDTH   = skvt_pkg::KEY_WIDTH,
  parameter int VALUE_WIDTH = skvt_pkg::VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [2:0]                       req_type,
  input  logic [KEY_WIDTH-1:0]             req_key,
  input  logic [VALUE_WIDTH-1:0]           req_value,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   req_position,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [1:0]                       status,
  output logic                             key_existed,
  output logic [KEY_WIDTH-1:0]             found_key,
  output logic [VALUE_WIDTH-1:0]           found_value,
  output logic [$clog2(TABLE_DEPTH)-1:0]   entry_position,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  skvt_pkg::dp_cmd_t  cmd;
  skvt_pkg::dp_stat_t stat;
  skvt_pkg::status_t  status_code;

  assign status = status_code;

  skvt_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  skvt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_key        (req_key),
    .req_value      (req_value),
    .req_position   (req_position),
    .status         (status_code),
    .key_existed    (key_existed),
    .found_key      (found_key),
    .found_value    (found_value),
    .entry_position (entry_position),
    .entry_count    (entry_count)
  );

  // a result never reports more entries than the table holds
  `SKVT_ASSERT_IMPL(a_count_bound, clk, rst, rsp_valid, entry_count <= CW'(TABLE_DEPTH))
  // full status only when the table really is full
  `SKVT_ASSERT_IMPL(a_full_count, clk, rst, rsp_valid && status_code == skvt_pkg::ST_FULL,
                    entry_count == CW'(TABLE_DEPTH))
  // an updated key is always a successful set
  `SKVT_ASSERT_IMPL(a_existed_ok, clk, rst, rsp_valid && key_existed,
                    status_code == skvt_pkg::ST_OK)
  // failed requests carry a cleared entry
  `SKVT_ASSERT_IMPL(a_fail_clear, clk, rst, rsp_valid && status_code != skvt_pkg::ST_OK,
                    !key_existed && found_key == '0 && found_value == '0 && entry_position == '0)
  // a request is never loaded in the cycle right after one was taken
  `SKVT_ASSERT_NEXT(a_load_idle, clk, rst, req_valid && !req_stall, cmd.op != skvt_pkg::OP_LOAD)

endmodule
